// File: rtl/core/cdo_pkg.sv
// ----------------------------------------------------------------------------
// Countdown digit overlay: shared types, constants and font
// Holds the register indices, the 8x16 digit font, the setup and hit
// structures passed between the pipeline modules, and small helper functions.
// ----------------------------------------------------------------------------
package cdo_pkg;

  // Largest screen dimension honoured; larger register values are clamped.
  localparam int MAX_DIM     = 4096;
  // The glyph scale is the clamped screen height shifted down by this amount.
  localparam int SCALE_SHIFT = 5;
  localparam int SCALE_MIN   = 2;

  // Configuration register indices.
  localparam logic [2:0] REG_SCREEN_WIDTH     = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_SHOWN_VALUE      = 3'd2;
  localparam logic [2:0] REG_BACKGROUND_COLOR = 3'd3;
  localparam logic [2:0] REG_FOREGROUND_COLOR = 3'd4;

  // Signed screen coordinate, wide enough for offsets left of the screen.
  typedef logic signed [13:0] coord_t;

  // Top eight rows of each digit glyph; row 0 sits in the top byte.
  // The lower eight rows of every glyph are blank.
  localparam logic [63:0] DIGIT_FONT [10] = '{
    64'h3C666E766666663C,
    64'h183818181818187E,
    64'h3C66060C1830667E,
    64'h3C66061C0606663C,
    64'h0C1C3C6C7E0C0C0C,
    64'h7E607C060606663C,
    64'h1C30607C6666663C,
    64'h7E060C1830303030,
    64'h3C66663C6666663C,
    64'h3C66663E06060C38
  };

  // Settings derived from the configuration registers.
  typedef struct packed {
    logic [12:0]      width;
    logic [12:0]      height;
    logic [3:0]       tens;
    logic [3:0]       ones;
    logic             tens_on;
    logic [10:0]      cell_w;
    logic [11:0]      cell_h;
    coord_t           tens_x;
    coord_t           ones_x;
    coord_t           top_y;
    logic [15:1][10:0] step;
    logic [31:0]      bg;
    logic [31:0]      fg;
  } setup_t;

  // Glyph cell position of one pixel, passed to the font stage.
  typedef struct packed {
    logic       valid;
    logic       in_tens;
    logic       in_ones;
    logic [2:0] col_tens;
    logic [2:0] col_ones;
    logic [3:0] row;
  } hit_t;

  // Font lookup: one pixel of a digit glyph at the given cell.
  function automatic logic font_pixel(logic [3:0] digit, logic [3:0] row, logic [2:0] col);
    logic [63:0] glyph;
    logic [7:0]  line;
    glyph = '0;
    if (digit <= 4'd9) begin
      glyph = DIGIT_FONT[digit];
    end
    line = glyph[{~row[2:0], 3'b000} +: 8];
    return !row[3] && line[~col];
  endfunction

  // Tens digit of a seven-bit value by parallel threshold compares.
  function automatic logic [3:0] tens_of(logic [6:0] value);
    logic [3:0] t;
    t = '0;
    for (int k = 1; k <= 12; k++) begin
      if (value >= 7'(10 * k)) begin
        t = 4'(k);
      end
    end
    return t;
  endfunction

endpackage

// File: rtl/core/cdo_cfg.sv
// ----------------------------------------------------------------------------
// Countdown digit overlay: configuration registers and derived geometry
// Holds the five registers and works out, over two register stages, the
// clamped screen size, glyph scale, digit positions and scale multiples.
// ----------------------------------------------------------------------------
module cdo_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [2:0]      wr_index,
  input  logic [31:0]     wr_data,
  output cdo_pkg::setup_t setup
);
  import cdo_pkg::*;

  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [6:0]  shown_value;
  logic [31:0] background_color;
  logic [31:0] foreground_color;

  // First derived stage.
  logic [12:0] width,   width_next;
  logic [12:0] height,  height_next;
  logic [7:0]  scale,   scale_next;
  logic [3:0]  tens,    tens_next;
  logic [3:0]  ones,    ones_next;
  logic        tens_on, tens_on_next;
  logic [12:0] scale_raw;

  // Second derived stage.
  logic [10:0]       cell_w, cell_w_next;
  logic [11:0]       cell_h, cell_h_next;
  coord_t            tens_x, tens_x_next;
  coord_t            ones_x, ones_x_next;
  coord_t            top_y,  top_y_next;
  logic [15:1][10:0] step,   step_next;
  logic [12:0]       group_w;
  logic [10:0]       gap;
  coord_t            diff_x;
  coord_t            diff_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= 13'd640;
      screen_height    <= 13'd480;
      shown_value      <= 7'd10;
      background_color <= 32'h0000_0000;
      foreground_color <= 32'h00FF_0000;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCREEN_WIDTH:     screen_width     <= wr_data[12:0];
        REG_SCREEN_HEIGHT:    screen_height    <= wr_data[12:0];
        REG_SHOWN_VALUE:      shown_value      <= wr_data[6:0];
        REG_BACKGROUND_COLOR: background_color <= wr_data;
        REG_FOREGROUND_COLOR: foreground_color <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    width_next   = (screen_width > 13'(MAX_DIM)) ? 13'(MAX_DIM) : screen_width;
    height_next  = (screen_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : screen_height;
    scale_raw    = height_next >> SCALE_SHIFT;
    scale_next   = (scale_raw < 13'(SCALE_MIN)) ? 8'(SCALE_MIN) : scale_raw[7:0];
    tens_next    = tens_of(shown_value);
    ones_next    = 4'(shown_value - 7'(10 * tens_next));
    tens_on_next = (tens_next != 4'd0) && (tens_next <= 4'd9);
  end

  always_ff @(posedge clk) begin
    width   <= width_next;
    height  <= height_next;
    scale   <= scale_next;
    tens    <= tens_next;
    ones    <= ones_next;
    tens_on <= tens_on_next;
  end

  // Offsets are halved toward zero, so a negative difference is rounded up.
  always_comb begin
    cell_w_next = {scale, 3'b000};
    cell_h_next = {scale, 4'b0000};
    group_w     = {1'b0, scale, 4'b0000} + {3'b000, scale, 2'b00};
    gap         = {scale, 3'b000} + {2'b00, scale, 1'b0};
    diff_x      = $signed({1'b0, width}) - $signed({1'b0, group_w});
    diff_y      = $signed({1'b0, height}) - $signed({2'b00, cell_h_next});
    tens_x_next = (diff_x + $signed({13'b0, diff_x[13]})) >>> 1;
    top_y_next  = (diff_y + $signed({13'b0, diff_y[13]})) >>> 1;
    ones_x_next = tens_x_next + $signed({3'b000, gap});
    for (int k = 1; k <= 15; k++) begin
      step_next[k] = 11'(k * scale);
    end
  end

  always_ff @(posedge clk) begin
    cell_w <= cell_w_next;
    cell_h <= cell_h_next;
    tens_x <= tens_x_next;
    ones_x <= ones_x_next;
    top_y  <= top_y_next;
    step   <= step_next;
  end

  assign setup = '{
    width:   width,
    height:  height,
    tens:    tens,
    ones:    ones,
    tens_on: tens_on,
    cell_w:  cell_w,
    cell_h:  cell_h,
    tens_x:  tens_x,
    ones_x:  ones_x,
    top_y:   top_y,
    step:    step,
    bg:      background_color,
    fg:      foreground_color
  };

endmodule

// File: rtl/core/cdo_locate.sv
// ----------------------------------------------------------------------------
// Countdown digit overlay: pixel locator
// Four register stages that take a pixel coordinate to its glyph cell:
// capture, screen bound check, offsets from each glyph, cell row and column.
// ----------------------------------------------------------------------------
module cdo_locate (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [11:0]     pixel_x,
  input  logic [11:0]     pixel_y,
  input  cdo_pkg::setup_t setup,
  output cdo_pkg::hit_t   hit
);
  import cdo_pkg::*;

  logic        v0, v1, v2;
  logic [11:0] px0, py0, px1, py1;
  logic        on1, on1_next, on2;
  coord_t      dx_tens, dx_ones, dy;
  hit_t        hit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      hit <= '0;
    end else begin
      v0  <= accept;
      v1  <= v0;
      v2  <= v1;
      hit <= hit_next;
    end
  end

  assign on1_next = ({1'b0, px0} < setup.width) && ({1'b0, py0} < setup.height);

  always_ff @(posedge clk) begin
    px0     <= pixel_x;
    py0     <= pixel_y;
    px1     <= px0;
    py1     <= py0;
    on1     <= on1_next;
    on2     <= on1;
    dx_tens <= $signed({2'b00, px1}) - $signed(setup.tens_x);
    dx_ones <= $signed({2'b00, px1}) - $signed(setup.ones_x);
    dy      <= $signed({2'b00, py1}) - $signed(setup.top_y);
  end

  // Cell index is the count of scale multiples not above the offset.
  always_comb begin
    hit_next.valid   = v2;
    hit_next.in_tens = on2 && setup.tens_on && !dx_tens[13]
                       && (dx_tens < $signed({3'b000, setup.cell_w}))
                       && !dy[13] && (dy < $signed({2'b00, setup.cell_h}));
    hit_next.in_ones = on2 && !dx_ones[13]
                       && (dx_ones < $signed({3'b000, setup.cell_w}))
                       && !dy[13] && (dy < $signed({2'b00, setup.cell_h}));
    hit_next.col_tens = '0;
    hit_next.col_ones = '0;
    hit_next.row      = '0;
    for (int k = 1; k <= 7; k++) begin
      hit_next.col_tens = hit_next.col_tens
                          + {2'b00, (dx_tens >= $signed({3'b000, setup.step[k]}))};
      hit_next.col_ones = hit_next.col_ones
                          + {2'b00, (dx_ones >= $signed({3'b000, setup.step[k]}))};
    end
    for (int k = 1; k <= 15; k++) begin
      hit_next.row = hit_next.row + {3'b000, (dy >= $signed({3'b000, setup.step[k]}))};
    end
  end

endmodule

// File: rtl/core/cdo_glyph.sv
// ----------------------------------------------------------------------------
// Countdown digit overlay: font lookup and result register
// Looks up the font bit of both digits at the located cell and registers
// the colour, the lit flag and the result strobe.
// ----------------------------------------------------------------------------
module cdo_glyph (
  input  logic            clk,
  input  logic            rst,
  input  cdo_pkg::hit_t   hit,
  input  cdo_pkg::setup_t setup,
  output logic            done,
  output logic            lit,
  output logic [31:0]     pixel_color
);
  import cdo_pkg::*;

  logic lit_next;

  assign lit_next = (hit.in_tens && font_pixel(setup.tens, hit.row, hit.col_tens))
                 || (hit.in_ones && font_pixel(setup.ones, hit.row, hit.col_ones));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      lit  <= 1'b0;
    end else begin
      done <= hit.valid;
      lit  <= hit.valid && lit_next;
    end
  end

  always_ff @(posedge clk) begin
    pixel_color <= lit_next ? setup.fg : setup.bg;
  end

endmodule

// File: rtl/core/countdown_digit_overlay_core.sv
// ----------------------------------------------------------------------------
// Countdown digit overlay core
// Draws a centred two-digit number in a scaled 8x16 digit font, one pixel
// per transfer. Usage:
//   Input channel: drive pixel_x and pixel_y with start high; the transfer
//   takes place at a rising edge where start is high and busy is low.
//   Output channel: each transfer yields exactly one result, shown on
//   pixel_color and lit for one cycle with done high. The receiver cannot
//   hold results off, so nothing ever backs up into the input side.
//   Pipeline: a pixel passes five register stages in all (capture, bound
//   check, glyph offsets, cell index, font lookup); done rises with the last.
//   Throughput is one pixel every cycle while busy is low, set by the fully
//   pipelined datapath; busy is raised only by reset, as described below.
//   Configuration: wr_en, wr_index and wr_data write one register per edge,
//   with indices 5 to 7 ignored. Write only while no pixel is in flight.
//   The pixel pipeline covers the settling of the derived geometry, so a
//   pixel may follow in the very next cycle.
//   Reset: rst is synchronous; it restores the register defaults, empties
//   the pipeline and holds busy high for the cycle after it is released.
// ----------------------------------------------------------------------------
module countdown_digit_overlay_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output logic        done,
  output logic [31:0] pixel_color,
  output logic        lit
);
  import cdo_pkg::*;

  setup_t setup;
  hit_t   hit;
  logic   accept;

  // busy only covers reset, so that the pipeline starts empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  // Registers plus the two-stage derivation of scale and glyph positions.
  cdo_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .setup    (setup)
  );

  // Coordinate to glyph cell: the first four pipeline stages.
  cdo_locate u_locate (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .setup   (setup),
    .hit     (hit)
  );

  // Font bit of both digits and the registered result.
  cdo_glyph u_glyph (
    .clk         (clk),
    .rst         (rst),
    .hit         (hit),
    .setup       (setup),
    .done        (done),
    .lit         (lit),
    .pixel_color (pixel_color)
  );

endmodule

// File: rtl/core/cdo_checker.sv
// ----------------------------------------------------------------------------
// Countdown digit overlay: port checker
// Watches the top-level ports for the fixed latency and result framing.
// ----------------------------------------------------------------------------
module cdo_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic lit
);

  // Reset empties the pipeline and blocks the following cycle.
  assert property (@(posedge clk) rst |=> !done && busy)
    else $error("pipeline not empty or busy low after reset");

  // Every accepted pixel gives a result on done as it leaves the pipeline.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |-> ##5 done)
    else $error("result missing after accepted pixel");

  // No result without a matching pixel accepted earlier in the pipeline.
  assert property (@(posedge clk) disable iff (rst) !(start && !busy) |-> ##5 !done)
    else $error("result without accepted pixel");

  // lit is only meaningful alongside the strobe.
  assert property (@(posedge clk) disable iff (rst) lit |-> done)
    else $error("lit raised outside a result");

endmodule

bind countdown_digit_overlay_core cdo_checker u_cdo_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Countdown digit overlay core testbench
// Feeds pixel coordinates through the command port under a series of screen,
// value and colour settings, predicts every pixel in a scoreboard and checks
// each colour and lit flag as it leaves the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import cdo_pkg::*;

  // Five register stages from capture to done.
  localparam int PIPE_LATENCY  = 5;
  // Cycles without any transfer on either side before the run is abandoned.
  localparam int QUIET_LIMIT   = 200;
  localparam int RANDOM_PIXELS = 1850;
  // The final stretch of the random part runs back to back with no idling.
  localparam int CALM_TAIL     = 200;
  localparam int SCALE_DIVISOR = 32;

  // Indices beyond the register file, which the block must ignore.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Upper eight rows of each digit; the lower eight rows are blank.
  localparam logic [7:0] GLYPH_ROWS [10][8] = '{
    '{8'h3C, 8'h66, 8'h6E, 8'h76, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
    '{8'h3C, 8'h66, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h66, 8'h7E},
    '{8'h3C, 8'h66, 8'h06, 8'h1C, 8'h06, 8'h06, 8'h66, 8'h3C},
    '{8'h0C, 8'h1C, 8'h3C, 8'h6C, 8'h7E, 8'h0C, 8'h0C, 8'h0C},
    '{8'h7E, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
    '{8'h1C, 8'h30, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h7E, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h30, 8'h30, 8'h30},
    '{8'h3C, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C},
    '{8'h3C, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h06, 8'h0C, 8'h38}
  };

  typedef struct packed {
    logic [31:0] color;
    logic        lit;
  } pixel_result_t;

  // Holds a copy of the overlay settings, works out the colour of every
  // pixel taken by the block and compares the results in order.
  class overlay_scoreboard;
    logic [12:0]   screen_w;
    logic [12:0]   screen_h;
    logic [6:0]    value;
    logic [31:0]   bg;
    logic [31:0]   fg;
    pixel_result_t pending[$];
    int            failures;

    function new();
      screen_w = 13'd640;
      screen_h = 13'd480;
      value    = 7'd10;
      bg       = 32'h0000_0000;
      fg       = 32'h00FF_0000;
      failures = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_SCREEN_WIDTH:     screen_w = data[12:0];
        REG_SCREEN_HEIGHT:    screen_h = data[12:0];
        REG_SHOWN_VALUE:      value    = data[6:0];
        REG_BACKGROUND_COLOR: bg       = data;
        REG_FOREGROUND_COLOR: fg       = data;
        default: ;
      endcase
    endfunction

    // Screen sizes above the supported maximum are clamped.
    function int visible_w();
      return (int'(screen_w) > MAX_DIM) ? MAX_DIM : int'(screen_w);
    endfunction

    function int visible_h();
      return (int'(screen_h) > MAX_DIM) ? MAX_DIM : int'(screen_h);
    endfunction

    function bit glyph_lit(int digit, int gx, int gy, int scale, int x, int y);
      int dx;
      int dy;
      dx = x - gx;
      dy = y - gy;
      if (digit > 9 || dx < 0 || dy < 0 || dx >= 8 * scale || dy >= 16 * scale) begin
        return 1'b0;
      end
      if (dy / scale >= 8) begin
        return 1'b0;
      end
      return GLYPH_ROWS[digit][dy / scale][7 - dx / scale];
    endfunction

    function pixel_result_t predict_pixel(logic [11:0] x, logic [11:0] y);
      int            w;
      int            h;
      int            scale;
      int            cell_w;
      int            cell_h;
      int            left;
      int            top;
      int            tens;
      int            ones;
      bit            on;
      pixel_result_t r;
      w    = visible_w();
      h    = visible_h();
      tens = int'(value) / 10;
      ones = int'(value) % 10;
      on   = 1'b0;
      if (int'(x) < w && int'(y) < h) begin
        scale = h / SCALE_DIVISOR;
        if (scale < 2) begin
          scale = 2;
        end
        cell_w = 8 * scale;
        cell_h = 16 * scale;
        // Signed division truncates toward zero, as the centring requires.
        left = (w - (2 * cell_w + cell_w / 2)) / 2;
        top  = (h - cell_h) / 2;
        if (tens > 0 && glyph_lit(tens, left, top, scale, int'(x), int'(y))) begin
          on = 1'b1;
        end
        if (glyph_lit(ones, left + cell_w + cell_w / 4, top, scale, int'(x), int'(y))) begin
          on = 1'b1;
        end
      end
      r.color = on ? fg : bg;
      r.lit   = on;
      return r;
    endfunction

    function void note_pixel(logic [11:0] x, logic [11:0] y);
      pending.push_back(predict_pixel(x, y));
    endfunction

    function void check_result(logic [31:0] color, logic on);
      pixel_result_t want;
      if (pending.size() == 0) begin
        $error("result with no pixel outstanding: pixel_color %h lit %b", color, on);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (color !== want.color) begin
        $error("pixel_color mismatch: expected %h, actual %h", want.color, color);
        failures++;
      end
      if (on !== want.lit) begin
        $error("lit mismatch: expected %b, actual %b", want.lit, on);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic        busy;
  logic [11:0] pixel_x     = '0;
  logic [11:0] pixel_y     = '0;
  logic        wr_en       = 1'b0;
  logic [2:0]  wr_index    = '0;
  logic [31:0] wr_data     = '0;
  logic        done;
  logic [31:0] pixel_color;
  logic        lit;

  overlay_scoreboard sb;
  int                quiet = 0;

  countdown_digit_overlay_core uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .done        (done),
    .pixel_color (pixel_color),
    .lit         (lit)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result monitor and watchdog. Sampling at the rising edge sees the values
  // that the block itself saw, so there is no race with its own registers.
  always @(posedge clk) begin
    if (done === 1'b1) begin
      sb.check_result(pixel_color, lit);
    end
    if ((!rst && start && busy === 1'b0) || done === 1'b1) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Presents one pixel and holds it until the block takes the transfer.
  // Start is left high so that the next pixel may follow straight on.
  task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
    start   <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_pixel(x, y);
  endtask

  task automatic pause_input(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Lets every pixel in flight come out before the settings change. Every
  // pixel yields a result, so an empty scoreboard means an empty pipeline;
  // the extra cycles are only a margin.
  task automatic settle_pipeline();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Writes all five registers back to back. The bits above each register's
  // width carry noise, which the block must discard. A write to a spare index
  // is mixed in now and then, or to all three spares when asked.
  task automatic program_overlay(input logic [12:0] w, input logic [12:0] h,
                                 input logic [6:0] v, input logic [31:0] back,
                                 input logic [31:0] fore, input bit all_spares);
    logic [31:0] noise;
    noise = $urandom();
    write_register(REG_SCREEN_WIDTH, {noise[31:13], w});
    noise = $urandom();
    write_register(REG_SCREEN_HEIGHT, {noise[31:13], h});
    noise = $urandom();
    write_register(REG_SHOWN_VALUE, {noise[31:7], v});
    write_register(REG_BACKGROUND_COLOR, back);
    write_register(REG_FOREGROUND_COLOR, fore);
    if (all_spares) begin
      for (int k = 0; k < 3; k++) begin
        write_register(REG_SPARE_LO + 3'(k), $urandom());
      end
    end else if ($urandom_range(0, 2) == 0) begin
      write_register(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
    end
    wr_en <= 1'b0;
  endtask

  // Screen dimension for a random phase: mostly ordinary sizes, with zero,
  // one, the clamp limit, oversized values and tiny screens mixed in.
  function automatic logic [12:0] pick_dimension();
    case ($urandom_range(0, 9))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'($urandom_range(4097, 8191));
      3:       return 13'($urandom_range(2, 80));
      4:       return 13'd4096;
      default: return 13'($urandom_range(100, 4096));
    endcase
  endfunction

  // One coordinate against a visible limit. Mode 0 is anywhere in the field,
  // mode 1 hugs the screen edge, and otherwise it falls on the screen or just
  // past it, where the digits are drawn.
  function automatic logic [11:0] pick_coord(input int lim, input int mode);
    int c;
    case (mode)
      0:       c = $urandom_range(0, 4095);
      1:       c = lim - 1 + $urandom_range(0, 2);
      default: c = $urandom_range(0, (lim + 3 > 4095) ? 4095 : lim + 3);
    endcase
    if (c < 0) begin
      c = 0;
    end
    if (c > 4095) begin
      c = 4095;
    end
    return 12'(c);
  endfunction

  initial begin
    int  pixels_sent;
    int  batch;
    int  mode;
    bit  bursty;
    bit  calm;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 640 by 480 showing 10. Two opposite corners, a stroke
    // of each digit, the first pixel past each edge and alternating bit patterns.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd220, 12'd125);
    send_pixel(12'd360, 12'd125);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd640, 12'd0);
    send_pixel(12'd0, 12'd480);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'hAAA, 12'h555);
    settle_pipeline();

    // Oversized screen clamped to the maximum, and a value above 99 whose
    // tens digit must not appear although the ones digit still does.
    program_overlay(13'h1FFF, 13'h1FFF, 7'd127, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_pixel(12'd2200, 12'd1100);
    send_pixel(12'd1000, 12'd1100);
    send_pixel(12'hFFF, 12'hFFF);
    settle_pipeline();

    // Zero width: every pixel is off screen.
    program_overlay(13'd0, 13'd480, 7'd99, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd220, 12'd125);
    settle_pipeline();

    // A tiny screen: minimum scale; both glyphs hang off the top edge, and the
    // tens glyph off the left edge, because the centring offsets go negative.
    program_overlay(13'd30, 13'd20, 7'd88, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd3, 12'd3);
    send_pixel(12'd5, 12'd10);
    send_pixel(12'd29, 12'd19);
    settle_pipeline();

    // Value zero draws only the ones digit; the spare indices are written
    // afterwards and must leave the settings untouched.
    program_overlay(13'd640, 13'd64, 7'd0, 32'hCAFE_0001, 32'h0BAD_F00D, 1'b1);
    send_pixel(12'd324, 12'd16);
    send_pixel(12'd310, 12'd20);
    settle_pipeline();

    // Random phases, each with fresh settings and a batch of pixels. Most
    // pixels land on or near the screen so that strokes are hit often.
    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      calm   = (pixels_sent >= RANDOM_PIXELS - CALM_TAIL);
      bursty = !calm && ($urandom_range(0, 3) != 0);
      program_overlay(pick_dimension(), pick_dimension(), 7'($urandom_range(0, 127)),
                      $urandom(), $urandom(), 1'b0);
      batch = $urandom_range(15, 80);
      for (int i = 0; i < batch; i++) begin
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode == 2) ? 1 : 2;
        send_pixel(pick_coord(sb.visible_w(), mode), pick_coord(sb.visible_h(), mode));
        pixels_sent++;
        if (bursty && $urandom_range(0, 2) == 0) begin
          pause_input($urandom_range(1, 3));
        end
      end
      settle_pipeline();
    end

    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
